@@ hw/rtl/rri_pkg.sv @@
// shared widths, constants and codes for the rtcp report interval pipeline
package rri_pkg;

  localparam int RANDOM_BITS_DEF = 16;

  localparam int CNT_W      = 16;
  localparam int BW_W       = 32;
  localparam int AVG_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // avg * n * 4e6 fits 54 bits, k * bw fits 34 bits
  localparam int NUM_W  = 54;
  localparam int DEN_W  = 34;
  // a base interval of 2^42 us or more always saturates the output
  localparam int BASE_W = 42;
  localparam int OUT_W  = 40;
  localparam int MIN_W  = 23;
  localparam int PROD_W = 32;

  localparam logic [MIN_W-1:0] MIN_US_FULL  = 23'd5000000;
  localparam logic [MIN_W-1:0] MIN_US_FIRST = 23'd2500000;

  localparam int NSCALE_W = 22;
  localparam logic [NSCALE_W-1:0] NUM_SCALE = 22'd4000000;

  // 100000 / 121828 reduced to 25000 / 30457
  localparam int SCALE_W = 15;
  localparam logic [SCALE_W-1:0] SCALE_K = 15'd25000;
  localparam int CDIV_W  = 15;
  localparam logic [CDIV_W-1:0] COMP_DIV = 15'd30457;

  // ceil(2^70 / 30457): multiply and shift gives the exact quotient below 2^55
  localparam int RECIP_SH = OUT_W + 2 * CDIV_W;
  localparam int RECIP_W  = 56;
  localparam logic [RECIP_W-1:0] COMP_RECIP =
    RECIP_W'(((128'd1 << RECIP_SH) + 128'(COMP_DIV) - 128'd1) / 128'(COMP_DIV));

  localparam logic [CFG_IDX_W-1:0] REG_SESSION_BW = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_SIZE   = 8'd1;

  localparam logic [BW_W-1:0]  BW_RESET  = 32'd1;
  localparam logic [AVG_W-1:0] AVG_RESET = 16'd200;

  typedef enum logic [1:0] {
    SHARE_ALL,
    SHARE_SEND,
    SHARE_RECV
  } share_t;

endpackage

@@ hw/rtl/rtcp_report_interval.sv @@
// RTCP report interval: front stages, base divider, scale stages and output register from in accept to out_valid
// throughput one item per cycle unless out_ready stalls; the base divider retires one quotient bit per stage
// the constant divide is a pipelined reciprocal multiply
// a stall on out_ready freezes the whole pipeline, nothing is dropped
// rst_n (synchronous) clears all valid bits, bandwidth resets to 1, packet size to 200
module rtcp_report_interval import rri_pkg::*; #(
  parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CNT_W-1:0]       in_member_count,
  input  logic [CNT_W-1:0]       in_sender_count,
  input  logic                   in_we_sent,
  input  logic                   in_first_report,
  input  logic [RANDOM_BITS-1:0] in_random_fraction,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_W-1:0]       out_interval_us,
  output logic                   out_saturated,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int MW = RANDOM_BITS + SCALE_W + 1;

  logic              adv;
  logic [BW_W-1:0]   bw_r;
  logic [AVG_W-1:0]  avg_r;

  logic              fr_valid;
  logic [NUM_W-1:0]  fr_num;
  logic [DEN_W-1:0]  fr_den;
  logic              fr_first;
  logic [MW-1:0]     fr_mult;

  logic              d1_valid;
  logic [BASE_W-1:0] d1_quot;
  logic              d1_over;
  logic [MW:0]       d1_side;

  logic              sc_valid;
  logic [OUT_W-1:0]  sc_quot;
  logic              sc_sat;

  logic              out_valid_r;
  logic [OUT_W-1:0]  interval_r;
  logic              sat_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r  <= BW_RESET;
      avg_r <= AVG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SESSION_BW: bw_r  <= cfg_data;
        REG_AVG_SIZE:   avg_r <= cfg_data[AVG_W-1:0];
        default: ;
      endcase
    end
  end

  rri_front #(.RANDOM_BITS(RANDOM_BITS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (adv),
    .in_valid        (in_valid),
    .member_count    (in_member_count),
    .sender_count    (in_sender_count),
    .we_sent         (in_we_sent),
    .first_report    (in_first_report),
    .random_fraction (in_random_fraction),
    .session_bw      (bw_r),
    .avg_size        (avg_r),
    .out_valid       (fr_valid),
    .out_num         (fr_num),
    .out_den         (fr_den),
    .out_first       (fr_first),
    .out_mult        (fr_mult)
  );

  // base interval: num / den, overflow beyond 42 bits means saturation
  rri_div #(.N_W(NUM_W), .D_W(DEN_W), .Q_W(BASE_W), .SIDE_W(MW + 1)) u_div_base (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (fr_valid),
    .in_num    (fr_num),
    .in_den    (fr_den),
    .in_side   ({fr_first, fr_mult}),
    .out_valid (d1_valid),
    .out_quot  (d1_quot),
    .out_over  (d1_over),
    .out_side  (d1_side)
  );

  rri_scale #(.RANDOM_BITS(RANDOM_BITS)) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (d1_valid),
    .in_quot   (d1_quot),
    .in_over   (d1_over),
    .in_first  (d1_side[MW]),
    .in_mult   (d1_side[MW-1:0]),
    .out_valid (sc_valid),
    .out_quot  (sc_quot),
    .out_sat   (sc_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sat_r      <= sc_sat;
      interval_r <= sc_sat ? {OUT_W{1'b1}} : sc_quot;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_interval_us = interval_r;
  assign out_saturated   = sat_r;

endmodule

@@ hw/rtl/rri_front.sv @@
// front stages: bandwidth share selection, numerator and denominator products
module rri_front import rri_pkg::*; #(
  parameter int RANDOM_BITS = RANDOM_BITS_DEF,
  localparam int MW = RANDOM_BITS + SCALE_W + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [CNT_W-1:0]       member_count,
  input  logic [CNT_W-1:0]       sender_count,
  input  logic                   we_sent,
  input  logic                   first_report,
  input  logic [RANDOM_BITS-1:0] random_fraction,
  input  logic [BW_W-1:0]        session_bw,
  input  logic [AVG_W-1:0]       avg_size,
  output logic                   out_valid,
  output logic [NUM_W-1:0]       out_num,
  output logic [DEN_W-1:0]       out_den,
  output logic                   out_first,
  output logic [MW-1:0]          out_mult
);

  localparam int RH_W = RANDOM_BITS + 1;

  share_t             share;
  logic [CNT_W-1:0]   n;
  logic [CNT_W+1:0]   senders_x4;
  logic [DEN_W-1:0]   bw_ext;
  logic [DEN_W-1:0]   den_nxt;
  logic [RH_W-1:0]    rh;

  logic               vld_a_r, vld_b_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DEN_W-1:0]   den_a_r, den_b_r;
  logic               first_a_r, first_b_r;
  logic [MW-1:0]      mult_a_r, mult_b_r;
  logic [NUM_W-1:0]   num_r;

  assign senders_x4 = {sender_count, 2'b00};

  always_comb begin
    share = SHARE_ALL;
    n     = member_count;
    if ((sender_count != '0) && (senders_x4 < (CNT_W+2)'(member_count))) begin
      if (we_sent) begin
        share = SHARE_SEND;
        n     = sender_count;
      end else begin
        share = SHARE_RECV;
        n     = member_count - sender_count;
      end
    end
  end

  // zero bandwidth counts as one byte per second
  assign bw_ext = (session_bw == '0) ? DEN_W'(1) : DEN_W'(session_bw);

  always_comb begin
    unique case (share)
      SHARE_ALL:  den_nxt = bw_ext << 2;
      SHARE_SEND: den_nxt = bw_ext;
      SHARE_RECV: den_nxt = bw_ext + (bw_ext << 1);
      default:    den_nxt = bw_ext << 2;
    endcase
  end

  assign rh = RH_W'(random_fraction) + (RH_W'(1) << (RANDOM_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_valid;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r    <= PROD_W'(avg_size) * PROD_W'(n);
      den_a_r   <= den_nxt;
      first_a_r <= first_report;
      mult_a_r  <= MW'(rh) * MW'(SCALE_K);
      num_r     <= NUM_W'(prod_r) * NUM_W'(NUM_SCALE);
      den_b_r   <= den_a_r;
      first_b_r <= first_a_r;
      mult_b_r  <= mult_a_r;
    end
  end

  assign out_valid = vld_b_r;
  assign out_num   = num_r;
  assign out_den   = den_b_r;
  assign out_first = first_b_r;
  assign out_mult  = mult_b_r;

endmodule

@@ hw/rtl/rri_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module rri_div import rri_pkg::*; #(
  parameter int N_W    = NUM_W,
  parameter int D_W    = DEN_W,
  parameter int Q_W    = BASE_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [N_W-1:0]    in_num,
  input  logic [D_W-1:0]    in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_quot,
  output logic              out_over,
  output logic [SIDE_W-1:0] out_side
);

  localparam int CW = ((N_W > D_W + Q_W) ? N_W : D_W + Q_W) + 1;

  logic [Q_W-1:0]    vld_r, vld_nxt;
  logic [N_W-1:0]    rem_r  [Q_W];
  logic [N_W-1:0]    rem_nxt[Q_W];
  logic [D_W-1:0]    den_r  [Q_W];
  logic [D_W-1:0]    den_nxt[Q_W];
  logic [Q_W-1:0]    quot_r [Q_W];
  logic [Q_W-1:0]    quot_nxt[Q_W];
  logic [Q_W-1:0]    over_r, over_nxt;
  logic [SIDE_W-1:0] side_r [Q_W];
  logic [SIDE_W-1:0] side_nxt[Q_W];

  logic [N_W-1:0]    cur_rem [Q_W];
  logic [D_W-1:0]    cur_den [Q_W];
  logic [Q_W-1:0]    cur_quot[Q_W];
  logic [CW-1:0]     shifted [Q_W];

  always_comb begin
    for (int j = 0; j < Q_W; j++) begin
      if (j == 0) begin
        cur_rem[j]  = in_num;
        cur_den[j]  = in_den;
        cur_quot[j] = '0;
        vld_nxt[j]  = in_valid;
        over_nxt[j] = CW'(in_num) >= (CW'(in_den) << Q_W);
        side_nxt[j] = in_side;
      end else begin
        cur_rem[j]  = rem_r[j-1];
        cur_den[j]  = den_r[j-1];
        cur_quot[j] = quot_r[j-1];
        vld_nxt[j]  = vld_r[j-1];
        over_nxt[j] = over_r[j-1];
        side_nxt[j] = side_r[j-1];
      end
      // stage j settles quotient bit Q_W-1-j
      shifted[j]  = CW'(cur_den[j]) << (Q_W - 1 - j);
      den_nxt[j]  = cur_den[j];
      rem_nxt[j]  = cur_rem[j];
      quot_nxt[j] = cur_quot[j];
      if (CW'(cur_rem[j]) >= shifted[j]) begin
        rem_nxt[j]              = cur_rem[j] - shifted[j][N_W-1:0];
        quot_nxt[j][Q_W-1-j]    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      over_r <= over_nxt;
      for (int j = 0; j < Q_W; j++) begin
        rem_r[j]  <= rem_nxt[j];
        den_r[j]  <= den_nxt[j];
        quot_r[j] <= quot_nxt[j];
        side_r[j] <= side_nxt[j];
      end
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign out_quot  = quot_r[Q_W-1];
  assign out_over  = over_r[Q_W-1];
  assign out_side  = side_r[Q_W-1];

endmodule

@@ hw/rtl/rri_scale.sv @@
// minimum floor, random scaling product and reciprocal divide by the e - 1.5 term
module rri_scale import rri_pkg::*; #(
  parameter int RANDOM_BITS = RANDOM_BITS_DEF,
  localparam int MW = RANDOM_BITS + SCALE_W + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [BASE_W-1:0] in_quot,
  input  logic              in_over,
  input  logic              in_first,
  input  logic [MW-1:0]     in_mult,
  output logic              out_valid,
  output logic [OUT_W-1:0]  out_quot,
  output logic              out_sat
);

  localparam int BL  = BASE_W / 2;
  localparam int BH  = BASE_W - BL;
  localparam int MH  = MW / 2;
  localparam int MHI = MW - MH;
  localparam int PW  = BASE_W + MW;
  localparam int SW  = PW - RANDOM_BITS;
  localparam int XW  = OUT_W + CDIV_W;
  localparam int XL  = XW / 2;
  localparam int XH  = XW - XL;
  localparam int RL  = RECIP_W / 2;
  localparam int RHI = RECIP_W - RL;
  localparam int TW0 = XL + RECIP_W;
  localparam int TW1 = XH + RECIP_W;
  localparam int PRW = XW + RECIP_W;

  logic [MIN_W-1:0]   min_us;
  logic [BASE_W-1:0]  base_nxt;
  logic               x_big;
  logic [PRW-1:0]     qsum;

  logic [7:0]         vld_r;
  logic [7:0]         sat_r;
  logic [BASE_W-1:0]  base_r;
  logic [MW-1:0]      mult_r;
  logic [BL+MH-1:0]   pp00_r;
  logic [BL+MHI-1:0]  pp01_r;
  logic [BH+MH-1:0]   pp10_r;
  logic [BH+MHI-1:0]  pp11_r;
  logic [BL+MW-1:0]   s0_r;
  logic [BH+MW-1:0]   s1_r;
  logic [PW-1:0]      p_r;
  logic [XW-1:0]      x_r;
  logic [XL+RL-1:0]   qp00_r;
  logic [XL+RHI-1:0]  qp01_r;
  logic [XH+RL-1:0]   qp10_r;
  logic [XH+RHI-1:0]  qp11_r;
  logic [TW0-1:0]     t0_r;
  logic [TW1-1:0]     t1_r;
  logic [OUT_W-1:0]   q_r;

  assign min_us   = in_first ? MIN_US_FIRST : MIN_US_FULL;
  assign base_nxt = (in_quot < BASE_W'(min_us)) ? BASE_W'(min_us) : in_quot;

  // drop the random fraction's scale; a value of 30457 * 2^40 or more is past the range
  assign x_big = p_r[PW-1:RANDOM_BITS] >= (SW'(COMP_DIV) << OUT_W);
  assign qsum  = PRW'(t0_r) + (PRW'(t1_r) << XL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r  <= {sat_r[6:4], sat_r[3] || x_big, sat_r[2:0], in_over};
      base_r <= base_nxt;
      mult_r <= in_mult;
      pp00_r <= (BL+MH)'(base_r[BL-1:0])       * (BL+MH)'(mult_r[MH-1:0]);
      pp01_r <= (BL+MHI)'(base_r[BL-1:0])      * (BL+MHI)'(mult_r[MW-1:MH]);
      pp10_r <= (BH+MH)'(base_r[BASE_W-1:BL])  * (BH+MH)'(mult_r[MH-1:0]);
      pp11_r <= (BH+MHI)'(base_r[BASE_W-1:BL]) * (BH+MHI)'(mult_r[MW-1:MH]);
      s0_r   <= (BL+MW)'(pp00_r) + ((BL+MW)'(pp01_r) << MH);
      s1_r   <= (BH+MW)'(pp10_r) + ((BH+MW)'(pp11_r) << MH);
      p_r    <= PW'(s0_r) + (PW'(s1_r) << BL);
      x_r    <= p_r[RANDOM_BITS+XW-1:RANDOM_BITS];
      qp00_r <= (XL+RL)'(x_r[XL-1:0])   * (XL+RL)'(COMP_RECIP[RL-1:0]);
      qp01_r <= (XL+RHI)'(x_r[XL-1:0])  * (XL+RHI)'(COMP_RECIP[RECIP_W-1:RL]);
      qp10_r <= (XH+RL)'(x_r[XW-1:XL])  * (XH+RL)'(COMP_RECIP[RL-1:0]);
      qp11_r <= (XH+RHI)'(x_r[XW-1:XL]) * (XH+RHI)'(COMP_RECIP[RECIP_W-1:RL]);
      t0_r   <= TW0'(qp00_r) + (TW0'(qp01_r) << RL);
      t1_r   <= TW1'(qp10_r) + (TW1'(qp11_r) << RL);
      q_r    <= qsum[RECIP_SH+OUT_W-1:RECIP_SH];
    end
  end

  assign out_valid = vld_r[7];
  assign out_sat   = sat_r[7];
  assign out_quot  = q_r;

endmodule
